@@ rtl/hktd_pkg.sv @@
// shared types and constants for the hall key threshold debounce block
package hktd_pkg;

  localparam int unsigned KEY_IDX_W  = 6;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned THRESH_W   = 12;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned ROW_W      = 2;
  localparam int unsigned COL_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_RST = 12'd2048;
  localparam logic [DEB_W-1:0]    DEB_RST    = 8'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 1'b1;

  typedef struct packed {
    logic             pressed;
    logic [NOW_W-1:0] stamp;
  } key_rec_t;

  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] idx;
    key_rec_t             rec;
  } key_wr_t;

  typedef struct packed {
    logic             pressed;
    logic             changed;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             skipped;
    logic             scan_changed;
  } result_t;

endpackage

@@ rtl/hktd_key_store.sv @@
// per-key state and change stamp memory with write-to-read forwarding
module hktd_key_store #(
  parameter int unsigned KEY_COUNT = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [hktd_pkg::KEY_IDX_W-1:0]   rd_idx_i,
  input  hktd_pkg::key_wr_t                wr_i,
  output hktd_pkg::key_rec_t               rd_rec_o
);

  localparam int unsigned KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  hktd_pkg::key_rec_t mem_q [KEY_COUNT];
  hktd_pkg::key_rec_t rd_rec_q;
  hktd_pkg::key_rec_t fwd_rec_q;
  logic [KEY_COUNT-1:0] valid_q;
  logic                 rd_valid_q;
  logic                 fwd_hit_q;
  logic [KEY_AW-1:0]    rd_addr;
  logic [KEY_AW-1:0]    wr_addr;

  assign rd_addr = rd_idx_i[KEY_AW-1:0];
  assign wr_addr = wr_i.idx[KEY_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_rec_q  <= mem_q[rd_addr];
      fwd_rec_q <= wr_i.rec;
    end
  end

  // an entry never written reads as released with a zero stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr];
        // write landing on the same edge as the read is not in the read data
        fwd_hit_q  <= wr_i.en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_rec_o = fwd_rec_q;
    end else if (rd_valid_q) begin
      rd_rec_o = rd_rec_q;
    end else begin
      rd_rec_o = '0;
    end
  end

endmodule

@@ rtl/hktd_eval.sv @@
// threshold, lockout check and grid position for one sample
module hktd_eval #(
  parameter int unsigned GRID_COLUMNS = 12,
  parameter int unsigned GRID_ROWS    = 4,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic [hktd_pkg::KEY_IDX_W-1:0]  key_idx_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic [hktd_pkg::NOW_W-1:0]      now_i,
  input  logic                            last_i,
  input  logic                            in_range_i,
  input  hktd_pkg::key_rec_t              rec_i,
  input  logic [hktd_pkg::THRESH_W-1:0]   threshold_i,
  input  logic [hktd_pkg::DEB_W-1:0]      debounce_i,
  input  logic                            seen_i,
  output hktd_pkg::result_t               res_o,
  output hktd_pkg::key_wr_t               wr_o,
  output logic                            seen_o
);

  localparam int unsigned CMP_W =
    (SAMPLE_BITS > hktd_pkg::THRESH_W) ? SAMPLE_BITS : hktd_pkg::THRESH_W;

  logic                           want;
  logic [hktd_pkg::NOW_W-1:0]     elapsed;
  logic                           change;
  logic [2:0]                     row;
  logic [hktd_pkg::KEY_IDX_W-1:0] base;
  logic [hktd_pkg::KEY_IDX_W-1:0] col;

  assign want    = CMP_W'(sample_i) < CMP_W'(threshold_i);
  assign elapsed = now_i - rec_i.stamp;
  assign change  = in_range_i && (elapsed > hktd_pkg::NOW_W'(debounce_i))
                   && (want != rec_i.pressed);

  // row search over the few row boundaries
  always_comb begin
    row  = '0;
    base = '0;
    for (int r = 1; r < int'(GRID_ROWS); r++) begin
      if (int'(key_idx_i) >= r * int'(GRID_COLUMNS)) begin
        row  = 3'(r);
        base = hktd_pkg::KEY_IDX_W'(r * int'(GRID_COLUMNS));
      end
    end
  end

  assign col = key_idx_i - base;

  always_comb begin
    res_o              = '0;
    res_o.skipped      = !in_range_i;
    res_o.scan_changed = last_i && (seen_i || change);
    if (in_range_i) begin
      res_o.pressed = change ? want : rec_i.pressed;
      res_o.changed = change;
      res_o.row     = row[hktd_pkg::ROW_W-1:0];
      res_o.column  = col[hktd_pkg::COL_W-1:0];
    end
  end

  assign wr_o.en          = change;
  assign wr_o.idx         = key_idx_i;
  assign wr_o.rec.pressed = want;
  assign wr_o.rec.stamp   = now_i;

  assign seen_o = last_i ? 1'b0 : (seen_i || change);

endmodule

@@ rtl/hall_key_threshold_debounce.sv @@
// top level of the hall key threshold debounce block
//
//   channel   | direction | signals                       | contents
//   s_axis    | in        | tvalid tready tdata tlast     | one sample per key
//   m_axis    | out       | tvalid tready tdata tuser     | one result per sample
//   cfg       | in        | we idx data                   | register writes
//
// one sample per cycle sustained while the output is not stalled; the path from a taken
// sample to the output is memory read with the input register, then the result register.
// the key store is read and written at most once per cycle, with the write of one
// sample forwarded to the sample right behind it.
// reset clears control state and the key valid bits and loads the config register defaults.
// a stalled output holds both stages; input is taken while the result waits only if the input stage is empty.
module hall_key_threshold_debounce #(
  parameter int unsigned KEY_COUNT    = 48,
  parameter int unsigned GRID_COLUMNS = 12,
  parameter int unsigned GRID_ROWS    = 4,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hktd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hktd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // key_index, sample, now_ms, zero fill
  input  logic [((hktd_pkg::KEY_IDX_W + SAMPLE_BITS + hktd_pkg::NOW_W + 7) / 8) * 8 - 1:0]
                                            s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pressed, changed, row, column, scan_changed, zero fill
  output logic [hktd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // skipped
  output logic                              m_axis_tuser_o
);

  localparam int unsigned GRID_KEYS = GRID_ROWS * GRID_COLUMNS;
  localparam int unsigned KEY_LIMIT = (KEY_COUNT < GRID_KEYS) ? KEY_COUNT : GRID_KEYS;
  localparam int unsigned SMP_LO    = hktd_pkg::KEY_IDX_W;
  localparam int unsigned NOW_LO    = SMP_LO + SAMPLE_BITS;

  logic [hktd_pkg::THRESH_W-1:0]  thresh_q;
  logic [hktd_pkg::DEB_W-1:0]     deb_q;
  logic                           s1_valid_q, s1_valid_d;
  logic                           out_valid_q, out_valid_d;
  logic                           seen_q, seen_d;
  logic [hktd_pkg::KEY_IDX_W-1:0] s1_idx_q;
  logic [SAMPLE_BITS-1:0]         s1_sample_q;
  logic [hktd_pkg::NOW_W-1:0]     s1_now_q;
  logic                           s1_last_q;
  logic                           s1_hit_q;
  hktd_pkg::result_t              res_q, res_d;
  hktd_pkg::key_wr_t              wr_eval;
  hktd_pkg::key_wr_t              wr;
  hktd_pkg::key_rec_t             rec;
  logic [hktd_pkg::KEY_IDX_W-1:0] in_idx;
  logic [hktd_pkg::KEY_IDX_W-1:0] rd_idx;
  logic                           in_hit;
  logic                           in_fire;
  logic                           out_free;
  logic                           s1_fire;

  assign in_idx   = s_axis_tdata_i[hktd_pkg::KEY_IDX_W-1:0];
  assign in_hit   = int'(in_idx) < int'(KEY_LIMIT);
  assign rd_idx   = in_hit ? in_idx : '0;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= hktd_pkg::THRESH_RST;
      deb_q       <= hktd_pkg::DEB_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        seen_q <= seen_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hktd_pkg::REG_PRESS_THRESHOLD: thresh_q <= cfg_data_i;
          hktd_pkg::REG_DEBOUNCE_MS:     deb_q    <= cfg_data_i[hktd_pkg::DEB_W-1:0];
          default:                       thresh_q <= thresh_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q    <= in_idx;
      s1_sample_q <= s_axis_tdata_i[NOW_LO-1:SMP_LO];
      s1_now_q    <= s_axis_tdata_i[NOW_LO+hktd_pkg::NOW_W-1:NOW_LO];
      s1_last_q   <= s_axis_tlast_i;
      s1_hit_q    <= in_hit;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  hktd_key_store #(
    .KEY_COUNT (KEY_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_idx_i (rd_idx),
    .wr_i     (wr),
    .rd_rec_o (rec)
  );

  hktd_eval #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_eval (
    .key_idx_i   (s1_idx_q),
    .sample_i    (s1_sample_q),
    .now_i       (s1_now_q),
    .last_i      (s1_last_q),
    .in_range_i  (s1_hit_q),
    .rec_i       (rec),
    .threshold_i (thresh_q),
    .debounce_i  (deb_q),
    .seen_i      (seen_q),
    .res_o       (res_d),
    .wr_o        (wr_eval),
    .seen_o      (seen_d)
  );

  // only commit the key update when the transaction moves to the output
  always_comb begin
    wr    = wr_eval;
    wr.en = wr_eval.en && s1_fire;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.skipped;
  assign m_axis_tdata_o  = {7'b0, res_q.scan_changed, res_q.column, res_q.row,
                            res_q.changed, res_q.pressed};

endmodule

@@ tb/hall_key_threshold_debounce_tb.sv @@
// self-checking testbench for the hall key threshold debounce block
module hall_key_threshold_debounce_tb;

  localparam int KEY_COUNT   = 48;
  localparam int GRID_COLS   = 12;
  localparam int SAMPLE_W    = 12;
  localparam int IN_DATA_W   = ((hktd_pkg::KEY_IDX_W + SAMPLE_W + hktd_pkg::NOW_W + 7) / 8) * 8;
  localparam int SETTLE      = 4;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 229;

  typedef enum logic {ROW_SAMPLE, ROW_SETTINGS} row_kind_e;
  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_EVERY_FOURTH, DRAIN_HOLD} drain_mode_e;

  // settings rows carry the threshold in smp and the lockout in now
  typedef struct packed {
    row_kind_e                       kind;
    logic [hktd_pkg::KEY_IDX_W-1:0]  key;
    logic [SAMPLE_W-1:0]             smp;
    logic [hktd_pkg::NOW_W-1:0]      now;
    logic                            last;
    logic                            typed;
    hktd_pkg::result_t               want;
  } stim_row_t;

  localparam hktd_pkg::result_t RES_QUIET   = '0;
  localparam hktd_pkg::result_t RES_K0_DOWN = '{pressed: 1'b1, changed: 1'b1, default: '0};
  localparam hktd_pkg::result_t RES_SKIP    = '{skipped: 1'b1, default: '0};

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // lockout after reset: stamp is zero, so nothing moves until now > 5
    '{ROW_SAMPLE,   6'd0,  12'd0,     32'd0,          1'b0, 1'b1, RES_QUIET},
    '{ROW_SAMPLE,   6'd0,  12'd0,     32'd5,          1'b0, 1'b1, RES_QUIET},
    '{ROW_SAMPLE,   6'd0,  12'd0,     32'd6,          1'b0, 1'b1, RES_K0_DOWN},
    '{ROW_SAMPLE,   6'd0,  12'd4095,  32'd7,          1'b0, 1'b0, RES_QUIET},
    // sample equal to threshold reads as released
    '{ROW_SAMPLE,   6'd0,  12'd2048,  32'd12,         1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd0,  12'd2047,  32'd100,        1'b1, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd47, 12'd0,     32'hFFFF_FFFF,  1'b0, 1'b0, RES_QUIET},
    // elapsed time wraps through zero
    '{ROW_SAMPLE,   6'd47, 12'd4095,  32'd3,          1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd47, 12'd4095,  32'd5,          1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd48, 12'd0,     32'd0,          1'b0, 1'b1, RES_SKIP},
    // scan end on a skipped key still reports and clears
    '{ROW_SAMPLE,   6'd63, 12'd4095,  32'hFFFF_FFFF,  1'b1, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd63, 12'd0,     32'd0,          1'b1, 1'b1, RES_SKIP},
    '{ROW_SAMPLE,   6'd12, 12'hAAA,   32'h5555_5555,  1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd35, 12'h555,   32'hAAAA_AAAA,  1'b1, 1'b0, RES_QUIET},
    '{ROW_SETTINGS, 6'd0,  12'd0,     32'd0,          1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd5,  12'd0,     32'd1000,       1'b0, 1'b0, RES_QUIET},
    // zero lockout: any nonzero time step lets the key move
    '{ROW_SETTINGS, 6'd0,  12'd4095,  32'd0,          1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd5,  12'd4094,  32'd1000,       1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd5,  12'd4095,  32'd1000,       1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd5,  12'd4095,  32'd1001,       1'b0, 1'b0, RES_QUIET},
    '{ROW_SETTINGS, 6'd0,  12'd2048,  32'd255,        1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd23, 12'd0,     32'd256,        1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd23, 12'd4095,  32'd511,        1'b0, 1'b0, RES_QUIET},
    '{ROW_SAMPLE,   6'd23, 12'd4095,  32'd512,        1'b1, 1'b0, RES_QUIET}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [hktd_pkg::CFG_IDX_W-1:0]  cfg_idx_i = hktd_pkg::REG_PRESS_THRESHOLD;
  logic [hktd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  // key_index, sample, now_ms, zero fill
  logic [IN_DATA_W-1:0]            s_axis_tdata_i = '0;
  logic                            s_axis_tlast_i = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  // pressed, changed, row, column, scan_changed, zero fill
  logic [hktd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  // skipped
  logic                            m_axis_tuser_o;

  hall_key_threshold_debounce dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [SAMPLE_W-1:0]          press_level;
  logic [hktd_pkg::DEB_W-1:0]   lockout_ms;
  logic                         key_down  [KEY_COUNT];
  logic [hktd_pkg::NOW_W-1:0]   key_stamp [KEY_COUNT];
  logic                         scan_dirty;

  hktd_pkg::result_t pending_results[$];
  int fault_count, result_count, sample_count, change_count, skip_count, scan_count;
  int settings_count, burst_left;

  function automatic hktd_pkg::result_t debounce_key(
      input logic [hktd_pkg::KEY_IDX_W-1:0] key,
      input logic [SAMPLE_W-1:0] smp,
      input logic [hktd_pkg::NOW_W-1:0] now,
      input logic last);
    hktd_pkg::result_t r;
    logic want;
    logic [hktd_pkg::NOW_W-1:0] elapsed;
    r = '0;
    if (key >= KEY_COUNT) begin
      r.skipped = 1'b1;
    end else begin
      want = smp < press_level;
      elapsed = now - key_stamp[key];
      if (elapsed > hktd_pkg::NOW_W'(lockout_ms) && want != key_down[key]) begin
        key_down[key] = want;
        key_stamp[key] = now;
        scan_dirty = 1'b1;
        r.changed = 1'b1;
      end
      r.pressed = key_down[key];
      r.row = hktd_pkg::ROW_W'(key / GRID_COLS);
      r.column = hktd_pkg::COL_W'(key % GRID_COLS);
    end
    if (last) begin
      r.scan_changed = scan_dirty;
      scan_dirty = 1'b0;
    end
    return r;
  endfunction

  // samples cluster around the threshold so the compare edge gets exercised
  function automatic logic [SAMPLE_W-1:0] pick_level();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 4095);
      1: v = (press_level == 0) ? 0 : $urandom_range(0, int'(press_level) - 1);
      2: v = $urandom_range(int'(press_level), 4095);
      default: v = int'(press_level) + $urandom_range(0, 4) - 2;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  task automatic push_sample(input logic [hktd_pkg::KEY_IDX_W-1:0] key,
                             input logic [SAMPLE_W-1:0] smp,
                             input logic [hktd_pkg::NOW_W-1:0] now, input logic last,
                             input logic typed, input hktd_pkg::result_t typed_res);
    int gap;
    hktd_pkg::result_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= IN_DATA_W'({now, smp, key});
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    r = debounce_key(key, smp, now, last);
    sample_count++;
    change_count += r.changed;
    skip_count += r.skipped;
    scan_count += last;
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // hold the input and let the pipe empty
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [SAMPLE_W-1:0] level,
                                input logic [hktd_pkg::DEB_W-1:0] lockout);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= hktd_pkg::REG_PRESS_THRESHOLD;
    cfg_data_i <= hktd_pkg::CFG_DATA_W'(level);
    @(posedge clk_i);
    cfg_idx_i <= hktd_pkg::REG_DEBOUNCE_MS;
    cfg_data_i <= hktd_pkg::CFG_DATA_W'(lockout);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    press_level = level;
    lockout_ms = lockout;
    settings_count++;
  endtask

  task automatic run_phase(input logic [SAMPLE_W-1:0] level,
                           input logic [hktd_pkg::DEB_W-1:0] lockout,
                           input logic [hktd_pkg::NOW_W-1:0] start_ms);
    logic [hktd_pkg::NOW_W-1:0] clock_ms;
    logic [hktd_pkg::KEY_IDX_W-1:0] key;
    int sent, run_len, step_max;
    clock_ms = start_ms;
    sent = 0;
    step_max = int'(lockout) / 4 + 2;
    wait_drained();
    apply_settings(level, lockout);
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(hktd_pkg::KEY_IDX_W'($urandom_range(0, 63)), SAMPLE_W'($urandom),
                    $urandom, 1'($urandom), 1'b0, '0);
        sent++;
      end else begin
        // a scan: time moves forward, a few hot keys get revisited
        run_len = $urandom_range(1, 16);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 19) == 0)
            key = hktd_pkg::KEY_IDX_W'($urandom_range(KEY_COUNT, 63));
          else if ($urandom_range(0, 1) == 1)
            key = hktd_pkg::KEY_IDX_W'($urandom_range(0, 7));
          else
            key = hktd_pkg::KEY_IDX_W'($urandom_range(0, KEY_COUNT - 1));
          clock_ms += hktd_pkg::NOW_W'($urandom_range(0, step_max));
          push_sample(key, pick_level(), clock_ms, i == run_len - 1, 1'b0, '0);
        end
        sent += run_len;
      end
    end
  endtask

  // receiver stall pattern
  drain_mode_e drain_mode = DRAIN_FREE;
  int drain_left = 0;
  int drain_tick = 0;

  always @(posedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_e'($urandom_range(0, 3));
      drain_left = (drain_mode == DRAIN_HOLD) ? $urandom_range(1, 30) : $urandom_range(8, 120);
    end
    drain_left--;
    drain_tick++;
    case (drain_mode)
      DRAIN_FREE:         m_axis_tready_i <= 1'b1;
      DRAIN_COIN:         m_axis_tready_i <= 1'($urandom_range(0, 1));
      DRAIN_EVERY_FOURTH: m_axis_tready_i <= (drain_tick % 4 == 0);
      default:            m_axis_tready_i <= 1'b0;
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    hktd_pkg::result_t got, exp;
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      got.pressed = m_axis_tdata_o[0];
      got.changed = m_axis_tdata_o[1];
      got.row = m_axis_tdata_o[3:2];
      got.column = m_axis_tdata_o[7:4];
      got.scan_changed = m_axis_tdata_o[8];
      got.skipped = m_axis_tuser_o;
      result_count++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result %0d: p=%0b c=%0b row=%0d col=%0d skip=%0b scan=%0b",
                   result_count, got.pressed, got.changed, got.row, got.column,
                   got.skipped, got.scan_changed);
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          fault_count++;
          if (fault_count <= 10)
            $display({"mismatch on result %0d: expected p=%0b c=%0b row=%0d col=%0d skip=%0b ",
                      "scan=%0b, got p=%0b c=%0b row=%0d col=%0d skip=%0b scan=%0b"},
                     result_count, exp.pressed, exp.changed, exp.row, exp.column,
                     exp.skipped, exp.scan_changed, got.pressed, got.changed, got.row,
                     got.column, got.skipped, got.scan_changed);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o === 1'b1) ||
        (m_axis_tvalid_o === 1'b1 && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("hall_key_threshold_debounce_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    press_level = hktd_pkg::THRESH_RST;
    lockout_ms = hktd_pkg::DEB_RST;
    scan_dirty = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_down[k] = 1'b0;
      key_stamp[k] = '0;
    end
    fault_count = 0;
    result_count = 0;
    sample_count = 0;
    change_count = 0;
    skip_count = 0;
    scan_count = 0;
    settings_count = 0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_SETTINGS) begin
        wait_drained();
        apply_settings(DIRECTED[i].smp, DIRECTED[i].now[hktd_pkg::DEB_W-1:0]);
      end else begin
        push_sample(DIRECTED[i].key, DIRECTED[i].smp, DIRECTED[i].now, DIRECTED[i].last,
                    DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    run_phase(12'd0, 8'd0, $urandom);
    run_phase(12'd4095, 8'd255, 32'hFFFF_FF00);
    run_phase(12'd4095, 8'd0, $urandom);
    run_phase(12'd0, 8'd255, $urandom);
    run_phase(hktd_pkg::THRESH_RST, hktd_pkg::DEB_RST, 32'hFFFF_FFF0);
    run_phase(SAMPLE_W'($urandom), hktd_pkg::DEB_W'($urandom_range(0, 20)), $urandom);
    run_phase(SAMPLE_W'($urandom), hktd_pkg::DEB_W'($urandom), $urandom);
    run_phase(SAMPLE_W'($urandom_range(1500, 2600)), hktd_pkg::DEB_W'($urandom_range(1, 8)),
              $urandom);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("run covered %0d samples over %0d register settings: %0d key changes,",
             sample_count, settings_count, change_count);
    $display("  %0d skipped keys, %0d scan ends, %0d results checked, %0d mismatches",
             skip_count, scan_count, result_count, fault_count);
    if (fault_count == 0) begin
      $display("hall_key_threshold_debounce_tb: PASS");
    end else begin
      $display("hall_key_threshold_debounce_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hktd_pkg.sv
rtl/hktd_key_store.sv
rtl/hktd_eval.sv
rtl/hall_key_threshold_debounce.sv
tb/hall_key_threshold_debounce_tb.sv
